// ===== rtl/windowed_trend_slope_defines.svh =====
// assertion macros for the windowed trend slope block
// used by the port checker; relies on clk and rst_n in the scope of use
`ifndef WINDOWED_TREND_SLOPE_DEFINES_SVH
`define WINDOWED_TREND_SLOPE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define WTS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define WTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/wts_pkg.sv =====
// shared types and constants for the windowed trend slope block
// no dependencies
`default_nettype none

package wts_pkg;

    // default ring depth
    localparam int HISTORY_DEPTH_DEF = 365;

    // operation codes carried in s_tuser
    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_UPDATE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // metric selector codes
    localparam logic [1:0] SEL_LUMINANCE   = 2'd0;
    localparam logic [1:0] SEL_COLOUR      = 2'd1;
    localparam logic [1:0] SEL_TEMPERATURE = 2'd2;
    localparam logic [1:0] SEL_INVALID     = 2'd3;

    // one stored sample
    typedef struct packed {
        logic [31:0] temperature;
        logic [31:0] colour;
        logic [31:0] luminance;
        logic [31:0] stamp;
    } entry_t;

    // query command handed to the engine
    typedef struct packed {
        logic [1:0]  metric_select;
        logic [31:0] window_start;
        logic [31:0] window_end;
        logic [9:0]  requested_limit;
    } query_cmd_t;

    // query result handed back
    typedef struct packed {
        logic [31:0] trend_slope;
        logic [8:0]  match_count;
        logic        query_error;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/wts_history.sv =====
// sample ring storage: one write port, one registered read port
// depends on wts_pkg
`default_nettype none

module wts_history #(
    parameter int DEPTH = wts_pkg::HISTORY_DEPTH_DEF
) (
    input  wire                      clk,
    input  wire                      wr_en,
    input  wire  [$clog2(DEPTH)-1:0] wr_addr,
    input  wire  wts_pkg::entry_t    wr_data,
    input  wire  [$clog2(DEPTH)-1:0] rd_addr,
    output wts_pkg::entry_t          rd_data
);

    wts_pkg::entry_t mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/wts_mul.sv =====
// shared 33x33 signed multiplier with registered product
// no dependencies
`default_nettype none

module wts_mul (
    input  wire                clk,
    input  wire signed [32:0]  a,
    input  wire signed [32:0]  b,
    output logic signed [65:0] product
);

    // one product per cycle
    always_ff @(posedge clk)
    begin
        product <= a * b;
    end

endmodule

`default_nettype wire

// ===== rtl/wts_engine.sv =====
// query sequencer: ring scan, sum accumulation, shift-add products, divide and rounding
// depends on wts_pkg and wts_mul
`default_nettype none

module wts_engine #(
    parameter int DEPTH = wts_pkg::HISTORY_DEPTH_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    input  wire  wts_pkg::query_cmd_t    cmd,
    input  wire  [$clog2(DEPTH+1)-1:0]   fill,
    output logic                         busy,
    output logic [$clog2(DEPTH)-1:0]     rd_addr,
    input  wire  wts_pkg::entry_t        rd_data,
    output logic                         res_valid,
    output wts_pkg::result_t             res,
    input  wire                          res_ready
);

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SX_W   = 32 + CNT_W;
    localparam int WIDE_W = 2 * CNT_W + 66;
    localparam int DIV_W  = $clog2(WIDE_W + 1);
    localparam int LIM_W  = (CNT_W > 10) ? CNT_W : 10;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_ISSUE  = 12'b0000_0000_0010,
        S_CHECK  = 12'b0000_0000_0100,
        S_MXX    = 12'b0000_0000_1000,
        S_MXY    = 12'b0000_0001_0000,
        S_ACC    = 12'b0000_0010_0000,
        S_SETUP  = 12'b0000_0100_0000,
        S_MUL    = 12'b0000_1000_0000,
        S_DIVSET = 12'b0001_0000_0000,
        S_DIV    = 12'b0010_0000_0000,
        S_ROUND  = 12'b0100_0000_0000,
        S_OUT    = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    wts_pkg::query_cmd_t cmd_reg, cmd_next;
    logic [PTR_W-1:0]  idx_reg, idx_next;
    logic [31:0]       x_reg, x_next;
    logic [31:0]       y_reg, y_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [SX_W-1:0]   sx_reg, sx_next;
    logic [WIDE_W-1:0] sy_reg, sy_next;
    logic [WIDE_W-1:0] sxx_reg, sxx_next;
    logic [WIDE_W-1:0] sxy_reg, sxy_next;
    logic [WIDE_W-1:0] acc_reg, acc_next;
    logic [WIDE_W-1:0] mcand_reg, mcand_next;
    logic [SX_W-1:0]   mplier_reg, mplier_next;
    logic              sub_reg, sub_next;
    logic [1:0]        pass_reg, pass_next;
    logic [WIDE_W-1:0] den_reg, den_next;
    logic              neg_reg, neg_next;
    logic [WIDE_W-1:0] rem_reg, rem_next;
    logic [WIDE_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0]  dcnt_reg, dcnt_next;
    logic [31:0]       slope_reg, slope_next;
    logic              err_reg, err_next;

    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_p;

    logic              in_window;
    logic              last_entry;
    logic [31:0]       metric;
    logic [WIDE_W-1:0] addend;
    logic [WIDE_W-1:0] acc_sum;
    logic [WIDE_W-1:0] rem_sh;
    logic [WIDE_W:0]   diff;
    logic              take;
    logic              round_up;
    logic [WIDE_W-1:0] q_round;
    logic [WIDE_W-1:0] q_limit;
    logic [WIDE_W-1:0] q_sat;
    logic [LIM_W-1:0]  n_ext;
    logic [LIM_W-1:0]  lim_ext;

    // shared multiplier: x*x, then y*x
    assign mul_a = (state_reg == S_MXY) ? {y_reg[31], y_reg} : {1'b0, x_reg};
    assign mul_b = {1'b0, x_reg};

    wts_mul u_mul (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (mul_p)
    );

    // scan helpers
    assign rd_addr    = idx_reg;
    assign in_window  = (rd_data.stamp >= cmd_reg.window_start) &&
                        (rd_data.stamp <= cmd_reg.window_end);
    assign last_entry = ((CNT_W'(idx_reg) + CNT_W'(1)) == fill);

    always_comb
    begin
        case (cmd_reg.metric_select)
            wts_pkg::SEL_LUMINANCE:   metric = rd_data.luminance;
            wts_pkg::SEL_COLOUR:      metric = rd_data.colour;
            wts_pkg::SEL_TEMPERATURE: metric = rd_data.temperature;
            default:                  metric = rd_data.luminance;
        endcase
    end

    // shift-add adder
    assign addend  = sub_reg ? ~mcand_reg : mcand_reg;
    assign acc_sum = acc_reg + addend + {{(WIDE_W-1){1'b0}}, sub_reg};

    // restoring divide step
    assign rem_sh = {rem_reg[WIDE_W-2:0], quo_reg[WIDE_W-1]};
    assign diff   = {1'b0, rem_sh} - {1'b0, den_reg};
    assign take   = ~diff[WIDE_W];

    // rounding to nearest, ties away from zero, then saturation
    assign round_up = ({rem_reg, 1'b0} >= {1'b0, den_reg});
    assign q_round  = quo_reg + {{(WIDE_W-1){1'b0}}, round_up};
    assign q_limit  = neg_reg ? WIDE_W'(33'h0_8000_0000) : WIDE_W'(33'h0_7FFF_FFFF);
    assign q_sat    = (q_round > q_limit) ? q_limit : q_round;

    // match count limited to the request
    assign n_ext   = LIM_W'(n_reg);
    assign lim_ext = LIM_W'(cmd_reg.requested_limit);

    always_comb
    begin
        res.trend_slope = slope_reg;
        res.match_count = (n_ext < lim_ext) ? n_ext[8:0] : lim_ext[8:0];
        res.query_error = err_reg;
    end

    assign busy      = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_OUT);

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        idx_next    = idx_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        n_next      = n_reg;
        sx_next     = sx_reg;
        sy_next     = sy_reg;
        sxx_next    = sxx_reg;
        sxy_next    = sxy_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        sub_next    = sub_reg;
        pass_next   = pass_reg;
        den_next    = den_reg;
        neg_next    = neg_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        dcnt_next   = dcnt_reg;
        slope_next  = slope_reg;
        err_next    = err_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd;
                    idx_next   = '0;
                    n_next     = '0;
                    sx_next    = '0;
                    sy_next    = '0;
                    sxx_next   = '0;
                    sxy_next   = '0;
                    pass_next  = 2'd0;
                    slope_next = '0;
                    err_next   = 1'b0;
                    state_next = (fill == '0) ? S_SETUP : S_ISSUE;
                end
            end

            S_ISSUE:
            begin
                state_next = S_CHECK;
            end

            // read data now valid: window test
            S_CHECK:
            begin
                x_next = rd_data.stamp;
                y_next = metric;
                if (in_window && (cmd_reg.metric_select == wts_pkg::SEL_INVALID))
                begin
                    err_next   = 1'b1;
                    n_next     = '0;
                    slope_next = '0;
                    state_next = S_OUT;
                end
                else if (in_window)
                begin
                    state_next = S_MXX;
                end
                else if (last_entry)
                begin
                    state_next = S_SETUP;
                end
                else
                begin
                    idx_next   = idx_reg + PTR_W'(1);
                    state_next = S_ISSUE;
                end
            end

            S_MXX:
            begin
                state_next = S_MXY;
            end

            // x*x product ready, y*x under way
            S_MXY:
            begin
                n_next     = n_reg + CNT_W'(1);
                sx_next    = sx_reg + {{(SX_W-32){1'b0}}, x_reg};
                sy_next    = sy_reg + {{(WIDE_W-32){y_reg[31]}}, y_reg};
                sxx_next   = sxx_reg + {{(WIDE_W-66){mul_p[65]}}, mul_p};
                state_next = S_ACC;
            end

            S_ACC:
            begin
                sxy_next = sxy_reg + {{(WIDE_W-66){mul_p[65]}}, mul_p};
                if (last_entry)
                begin
                    state_next = S_SETUP;
                end
                else
                begin
                    idx_next   = idx_reg + PTR_W'(1);
                    state_next = S_ISSUE;
                end
            end

            // load operands for each shift-add pass, ending early on under two matches or a zero denominator
            S_SETUP:
            begin
                state_next = S_MUL;
                case (pass_reg)
                    2'd0:
                    begin
                        if (n_reg < CNT_W'(2))
                        begin
                            slope_next = '0;
                            state_next = S_OUT;
                        end
                        acc_next    = '0;
                        mcand_next  = sxx_reg;
                        mplier_next = {{(SX_W-CNT_W){1'b0}}, n_reg};
                        sub_next    = 1'b0;
                    end
                    2'd1:
                    begin
                        mcand_next  = {{(WIDE_W-SX_W){1'b0}}, sx_reg};
                        mplier_next = sx_reg;
                        sub_next    = 1'b1;
                    end
                    2'd2:
                    begin
                        den_next = acc_reg;
                        if (acc_reg == '0)
                        begin
                            slope_next = '0;
                            state_next = S_OUT;
                        end
                        acc_next    = '0;
                        mcand_next  = sxy_reg;
                        mplier_next = {{(SX_W-CNT_W){1'b0}}, n_reg};
                        sub_next    = 1'b0;
                    end
                    default:
                    begin
                        mcand_next  = sy_reg;
                        mplier_next = sx_reg;
                        sub_next    = 1'b1;
                    end
                endcase
            end

            // one multiplier bit per cycle, stop when no bits remain
            S_MUL:
            begin
                if (mplier_reg == '0)
                begin
                    pass_next  = pass_reg + 2'd1;
                    state_next = (pass_reg == 2'd3) ? S_DIVSET : S_SETUP;
                end
                else
                begin
                    if (mplier_reg[0])
                    begin
                        acc_next = acc_sum;
                    end
                    mcand_next  = {mcand_reg[WIDE_W-2:0], 1'b0};
                    mplier_next = {1'b0, mplier_reg[SX_W-1:1]};
                end
            end

            // numerator magnitude and sign
            S_DIVSET:
            begin
                neg_next   = acc_reg[WIDE_W-1];
                quo_next   = acc_reg[WIDE_W-1] ? (~acc_reg + WIDE_W'(1)) : acc_reg;
                rem_next   = '0;
                dcnt_next  = '0;
                state_next = S_DIV;
            end

            S_DIV:
            begin
                rem_next  = take ? diff[WIDE_W-1:0] : rem_sh;
                quo_next  = {quo_reg[WIDE_W-2:0], take};
                dcnt_next = dcnt_reg + DIV_W'(1);
                if (dcnt_reg == DIV_W'(WIDE_W - 1))
                begin
                    state_next = S_ROUND;
                end
            end

            S_ROUND:
            begin
                slope_next = neg_reg ? (32'd0 - q_sat[31:0]) : q_sat[31:0];
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        idx_reg    <= idx_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        n_reg      <= n_next;
        sx_reg     <= sx_next;
        sy_reg     <= sy_next;
        sxx_reg    <= sxx_next;
        sxy_reg    <= sxy_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        sub_reg    <= sub_next;
        pass_reg   <= pass_next;
        den_reg    <= den_next;
        neg_reg    <= neg_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        dcnt_reg   <= dcnt_next;
        slope_reg  <= slope_next;
        err_reg    <= err_next;
    end

endmodule

`default_nettype wire

// ===== rtl/windowed_trend_slope.sv =====
// append and update write the ring directly and never make the block busy; a query
// reads each stored entry in turn from the history, and each match uses the shared
// multiplier; then come the shift-add products, 84 divide steps at the default depth
// and the rounding
// throughput: one beat at a time; the input is not ready during a query
// reset: asynchronous active low, ring empty, counters and current sample zero
`default_nettype none

module windowed_trend_slope #(
    parameter int HISTORY_DEPTH = wts_pkg::HISTORY_DEPTH_DEF
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_tvalid,
    output logic         s_tready,
    // stamp, luminance, colour_error, panel_temperature, metric_select,
    // window_start, window_end, requested_limit, zero pad
    input  wire  [207:0] s_tdata,
    // operation
    input  wire  [1:0]   s_tuser,
    output logic         m_tvalid,
    input  wire          m_tready,
    // trend_slope, match_count, zero pad
    output logic [47:0]  m_tdata,
    // query_error
    output logic [0:0]   m_tuser
);

    localparam int PTR_W = $clog2(HISTORY_DEPTH);
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

    logic              accept;
    logic              wr_en;
    logic              eng_busy;
    logic              res_valid;
    logic              res_ready;
    logic [PTR_W-1:0]  rd_addr;

    wts_pkg::entry_t     wr_entry;
    wts_pkg::entry_t     rd_entry;
    wts_pkg::query_cmd_t cmd;
    wts_pkg::result_t    res;

    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [31:0]      cur_lum_reg, cur_lum_next;
    logic [31:0]      cur_col_reg, cur_col_next;
    logic [31:0]      cur_tmp_reg, cur_tmp_next;
    logic [31:0]      upd_cnt_reg, upd_cnt_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [47:0]      m_tdata_reg, m_tdata_next;
    logic             m_tuser_reg, m_tuser_next;

    // input beat decode
    assign s_tready = ~eng_busy;
    assign accept   = s_tvalid & s_tready;
    assign wr_en    = accept && ((s_tuser == wts_pkg::OP_APPEND) ||
                                 (s_tuser == wts_pkg::OP_UPDATE));

    assign cmd.metric_select   = s_tdata[129:128];
    assign cmd.window_start    = s_tdata[161:130];
    assign cmd.window_end      = s_tdata[193:162];
    assign cmd.requested_limit = s_tdata[203:194];

    // append stores the given sample, update stores the previous current one
    always_comb
    begin
        if (s_tuser == wts_pkg::OP_APPEND)
        begin
            wr_entry.stamp       = s_tdata[31:0];
            wr_entry.luminance   = s_tdata[63:32];
            wr_entry.colour      = s_tdata[95:64];
            wr_entry.temperature = s_tdata[127:96];
        end
        else
        begin
            wr_entry.stamp       = upd_cnt_reg;
            wr_entry.luminance   = cur_lum_reg;
            wr_entry.colour      = cur_col_reg;
            wr_entry.temperature = cur_tmp_reg;
        end
    end

    // ring pointer, fill level and current sample
    always_comb
    begin
        wp_next      = wp_reg;
        fill_next    = fill_reg;
        cur_lum_next = cur_lum_reg;
        cur_col_next = cur_col_reg;
        cur_tmp_next = cur_tmp_reg;
        upd_cnt_next = upd_cnt_reg;
        if (wr_en)
        begin
            wp_next = (wp_reg == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + PTR_W'(1);
            if (fill_reg != CNT_W'(HISTORY_DEPTH))
            begin
                fill_next = fill_reg + CNT_W'(1);
            end
        end
        if (accept && (s_tuser == wts_pkg::OP_UPDATE))
        begin
            cur_lum_next = s_tdata[63:32];
            cur_col_next = s_tdata[95:64];
            cur_tmp_next = s_tdata[127:96];
            upd_cnt_next = upd_cnt_reg + 32'd1;
        end
    end

    wts_history #(
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wp_reg),
        .wr_data (wr_entry),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    wts_engine #(
        .DEPTH (HISTORY_DEPTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept && (s_tuser == wts_pkg::OP_QUERY)),
        .cmd       (cmd),
        .fill      (fill_reg),
        .busy      (eng_busy),
        .rd_addr   (rd_addr),
        .rd_data   (rd_entry),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    // output register
    assign res_ready = ~m_tvalid_reg | m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {7'd0, res.match_count, res.trend_slope};
            m_tuser_next  = res.query_error;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg       <= '0;
            fill_reg     <= '0;
            cur_lum_reg  <= '0;
            cur_col_reg  <= '0;
            cur_tmp_reg  <= '0;
            upd_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            wp_reg       <= wp_next;
            fill_reg     <= fill_next;
            cur_lum_reg  <= cur_lum_next;
            cur_col_reg  <= cur_col_next;
            cur_tmp_reg  <= cur_tmp_next;
            upd_cnt_reg  <= upd_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

endmodule

`default_nettype wire

// ===== rtl/wts_checker.sv =====
// port-level checker for the windowed trend slope block, with its bind
// depends on wts_pkg and windowed_trend_slope_defines.svh
`default_nettype none
`include "windowed_trend_slope_defines.svh"

module wts_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire [1:0]  s_tuser,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [47:0] m_tdata,
    input wire [0:0]  m_tuser
);

    // a stalled result beat holds
    `WTS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

    // a query beat makes the block busy
    `WTS_ASSERT_NEXT(a_query_busy, s_tvalid && s_tready && (s_tuser == wts_pkg::OP_QUERY), !s_tready, "ready after query beat")

    // append and update never leave the block busy
    `WTS_ASSERT_NEXT(a_store_ready, s_tvalid && s_tready && ((s_tuser == wts_pkg::OP_APPEND) || (s_tuser == wts_pkg::OP_UPDATE)), s_tready, "busy after store beat")

    // an error result carries zero slope and zero count
    `WTS_ASSERT_NOW(a_err_zero, m_tvalid && m_tuser[0], m_tdata[40:0] == 41'd0, "error result with data")

endmodule

bind windowed_trend_slope wts_checker u_wts_checker (.*);

`default_nettype wire

// ===== tb/windowed_trend_slope_test.sv =====
// self-checking testbench for windowed_trend_slope: directed table then random beats,
// every query result checked against its typed row result or an exact 128-bit least-squares slope predictor
// depends on wts_pkg and the windowed_trend_slope rtl
`timescale 1ns / 1ps

module windowed_trend_slope_test;

    localparam int DEPTH       = wts_pkg::HISTORY_DEPTH_DEF;
    localparam int RAND_ITEMS  = 430;
    localparam int HOLD_CYCLES = 3000;
    localparam int DRAIN       = 2500;
    localparam longint CYCLE_LIMIT = 64'd6000000;

    typedef struct {
        wts_pkg::op_t op;
        logic [31:0]  stamp;
        logic [31:0]  lum;
        logic [31:0]  col;
        logic [31:0]  tmp;
        logic [1:0]   sel;
        logic [31:0]  wstart;
        logic [31:0]  wend;
        logic [9:0]   limit;
    } sample_cmd_t;

    typedef struct {
        logic [31:0] slope;
        logic [8:0]  count;
        logic        err;
    } trend_t;

    // directed row: command plus optional hand-written result
    typedef struct {
        sample_cmd_t cmd;
        bit          typed;
        trend_t      res;
    } row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [207:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [47:0]  m_tdata;
    logic [0:0]   m_tuser;

    // predictor state
    logic [31:0] ring_stamp [DEPTH];
    logic [31:0] ring_lum [DEPTH];
    logic [31:0] ring_col [DEPTH];
    logic [31:0] ring_tmp [DEPTH];
    int unsigned wr_ptr;
    int unsigned fill;
    logic [31:0] cur_lum;
    logic [31:0] cur_col;
    logic [31:0] cur_tmp;
    logic [31:0] upd_count;

    trend_t pending_trends[$];
    row_t   dir_rows[$];
    int     errors = 0;
    longint cycles = 0;
    bit     hold_req;

    windowed_trend_slope uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 20 ns clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("windowed_trend_slope verification failed");
            $finish;
        end
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    function automatic void add_row(input sample_cmd_t c, input bit typed, input trend_t res);
        row_t r;
        r.cmd    = c;
        r.typed  = typed;
        r.res    = res;
        dir_rows = {dir_rows, r};
    endfunction

    function automatic void ring_store(input logic [31:0] st, input logic [31:0] l,
                                       input logic [31:0] c, input logic [31:0] t);
        ring_stamp[wr_ptr] = st;
        ring_lum[wr_ptr]   = l;
        ring_col[wr_ptr]   = c;
        ring_tmp[wr_ptr]   = t;
        wr_ptr = (wr_ptr + 1 == DEPTH) ? 0 : wr_ptr + 1;
        if (fill < DEPTH)
            fill++;
    endfunction

    // exact least-squares slope over the stored window
    function automatic trend_t trend_of(input sample_cmd_t c);
        trend_t r;
        logic signed [127:0] sx, sy, sxx, sxy, num, den, xw, yw;
        logic [127:0] mag, q, rem;
        logic [31:0] v;
        int unsigned n;
        bit neg;
        sx = 0; sy = 0; sxx = 0; sxy = 0; n = 0;
        r = '{32'd0, 9'd0, 1'b0};
        for (int i = 0; i < fill; i++)
        begin
            if (ring_stamp[i] < c.wstart || ring_stamp[i] > c.wend)
                continue;
            if (c.sel == wts_pkg::SEL_INVALID)
            begin
                r.err = 1'b1;
                return r;
            end
            v  = (c.sel == wts_pkg::SEL_LUMINANCE) ? ring_lum[i] :
                 (c.sel == wts_pkg::SEL_COLOUR) ? ring_col[i] : ring_tmp[i];
            xw = {96'd0, ring_stamp[i]};
            yw = {{96{v[31]}}, v};
            n++;
            sx  = sx + xw;
            sy  = sy + yw;
            sxx = sxx + xw * xw;
            sxy = sxy + yw * xw;
        end
        if (n >= 2)
        begin
            den = $signed(128'(n)) * sxx - sx * sx;
            if (den != 0)
            begin
                num = $signed(128'(n)) * sxy - sy * sx;
                neg = num[127];
                mag = neg ? -num : num;
                q   = mag / den;
                rem = mag % den;
                if ((rem << 1) >= den)
                    q = q + 1;
                if (neg && q > 128'h80000000)
                    q = 128'h80000000;
                if (!neg && q > 128'h7FFFFFFF)
                    q = 128'h7FFFFFFF;
                r.slope = neg ? -q[31:0] : q[31:0];
            end
        end
        r.count = (n < c.limit) ? n[8:0] : c.limit[8:0];
        return r;
    endfunction

    // apply one accepted beat to the predictor, queue any result
    function automatic void predict(input sample_cmd_t c, input bit typed, input trend_t res);
        case (c.op)
            wts_pkg::OP_APPEND: ring_store(c.stamp, c.lum, c.col, c.tmp);
            wts_pkg::OP_UPDATE:
            begin
                ring_store(upd_count, cur_lum, cur_col, cur_tmp);
                cur_lum = c.lum;
                cur_col = c.col;
                cur_tmp = c.tmp;
                upd_count = upd_count + 1;
            end
            wts_pkg::OP_QUERY: pending_trends = {pending_trends, (typed ? res : trend_of(c))};
            default: ;
        endcase
    endfunction

    task automatic send(input sample_cmd_t c, input bit typed, input trend_t res);
        int gap;
        gap = $urandom_range(0, 19);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= {4'd0, c.limit, c.wend, c.wstart, c.sel, c.tmp, c.col, c.lum, c.stamp};
        s_tuser  <= c.op;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        predict(c, typed, res);
    endtask

    function automatic logic [31:0] pick_stamp();
        return ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 600);
    endfunction

    function automatic sample_cmd_t random_cmd();
        sample_cmd_t c;
        int roll;
        roll     = $urandom_range(0, 99);
        c.op     = (roll < 20) ? wts_pkg::OP_QUERY : (roll < 22) ? wts_pkg::OP_NONE :
                   (roll < 62) ? wts_pkg::OP_APPEND : wts_pkg::OP_UPDATE;
        c.stamp  = pick_stamp();
        c.lum    = $urandom;
        c.col    = $urandom;
        c.tmp    = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 2000) - 1000;
        c.sel    = ($urandom_range(0, 9) == 0) ? wts_pkg::SEL_INVALID : $urandom_range(0, 2);
        c.wstart = pick_stamp();
        c.wend   = ($urandom_range(0, 4) == 0) ? $urandom : c.wstart + $urandom_range(0, 400);
        if ($urandom_range(0, 7) == 0)
        begin
            c.wstart = 32'd0;
            c.wend   = 32'hFFFFFFFF;
        end
        c.limit  = $urandom_range(0, 1023);
        return c;
    endfunction

    // result side: random stalls plus one long hold-off on request
    initial
    begin
        int gap;
        bit hold_done;
        trend_t want;
        hold_done = 1'b0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = $urandom_range(0, 19);
            if ($urandom_range(0, 3) == 0)
                gap = 0;
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                gap = HOLD_CYCLES;
            end
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            if (pending_trends.size() == 0)
            begin
                report("unexpected result", m_tdata[31:0], 32'd0);
            end
            else
            begin
                want = pending_trends.pop_front();
                if (m_tdata[31:0] !== want.slope)
                    report("trend_slope", m_tdata[31:0], want.slope);
                if (m_tdata[40:32] !== want.count)
                    report("match_count", 32'(m_tdata[40:32]), 32'(want.count));
                if (m_tuser[0] !== want.err)
                    report("query_error", 32'(m_tuser[0]), 32'(want.err));
            end
        end
    end

    // stimulus
    initial
    begin
        sample_cmd_t c;
        trend_t none;
        none     = '{32'd0, 9'd0, 1'b0};
        hold_req = 1'b0;
        wr_ptr   = 0;
        fill     = 0;
        cur_lum  = 0;
        cur_col  = 0;
        cur_tmp  = 0;
        upd_count = 0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = wts_pkg::OP_NONE;

        // empty ring queries
        add_row('{wts_pkg::OP_QUERY, 0, 0, 0, 0, wts_pkg::SEL_LUMINANCE, 0, 32'hFFFFFFFF, 1023},
                1, none);
        add_row('{wts_pkg::OP_QUERY, 0, 0, 0, 0, wts_pkg::SEL_INVALID, 0, 32'hFFFFFFFF, 1023},
                1, none);
        // extreme samples at both stamp ends
        add_row('{wts_pkg::OP_APPEND, 0, 32'h7FFFFFFF, 32'h80000000, 0, 0, 0, 0, 0}, 0, none);
        add_row('{wts_pkg::OP_APPEND, 32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                  32'hFFFFFFFF, 0, 0, 0, 0}, 0, none);
        add_row('{wts_pkg::OP_QUERY, 0, 0, 0, 0, wts_pkg::SEL_LUMINANCE, 0, 32'hFFFFFFFF, 1023},
                0, none);
        add_row('{wts_pkg::OP_QUERY, 0, 0, 0, 0, wts_pkg::SEL_COLOUR, 0, 32'hFFFFFFFF, 1023},
                0, none);
        // invalid selector with a match
        add_row('{wts_pkg::OP_QUERY, 0, 0, 0, 0, wts_pkg::SEL_INVALID, 0, 32'hFFFFFFFF, 1023},
                1, '{32'd0, 9'd0, 1'b1});
        // window with start above end
        add_row('{wts_pkg::OP_QUERY, 0, 0, 0, 0, wts_pkg::SEL_LUMINANCE, 10, 5, 1023}, 1, none);
        // single match
        add_row('{wts_pkg::OP_QUERY, 0, 0, 0, 0, wts_pkg::SEL_LUMINANCE, 0, 0, 1023}, 1,
                '{32'd0, 9'd1, 1'b0});
        // equal stamps give a zero denominator
        add_row('{wts_pkg::OP_APPEND, 0, 32'h00010000, 32'h12345678, 32'h00050000, 0, 0, 0, 0},
                0, none);
        add_row('{wts_pkg::OP_QUERY, 0, 0, 0, 0, wts_pkg::SEL_COLOUR, 0, 0, 1023}, 1,
                '{32'd0, 9'd2, 1'b0});
        // zero limit still computes the slope
        add_row('{wts_pkg::OP_QUERY, 0, 0, 0, 0, wts_pkg::SEL_TEMPERATURE, 0, 32'hFFFFFFFF, 0},
                0, none);
        add_row('{wts_pkg::OP_QUERY, 0, 0, 0, 0, wts_pkg::SEL_LUMINANCE, 0, 32'hFFFFFFFF, 1},
                0, none);
        // updates and the ignored code
        add_row('{wts_pkg::OP_UPDATE, 32'hFFFFFFFF, 32'h00020000, 32'hFFFF0000, 32'h00300000,
                  0, 0, 0, 0}, 0, none);
        add_row('{wts_pkg::OP_UPDATE, 0, 32'h00050000, 32'h00010000, 32'hFFD00000,
                  0, 0, 0, 0}, 0, none);
        add_row('{wts_pkg::OP_UPDATE, 0, 32'h7FFFFFFF, 32'h80000000, 32'h0, 0, 0, 0, 0},
                0, none);
        add_row('{wts_pkg::OP_NONE, 3, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                  wts_pkg::SEL_INVALID, 32'hFFFFFFFF, 32'hFFFFFFFF, 10'h3FF}, 0, none);
        add_row('{wts_pkg::OP_QUERY, 0, 0, 0, 0, wts_pkg::SEL_TEMPERATURE, 0, 10, 1023},
                0, none);
        add_row('{wts_pkg::OP_QUERY, 0, 0, 0, 0, wts_pkg::SEL_LUMINANCE, 0, 10, 2}, 0, none);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].res);

        for (int k = 0; k < RAND_ITEMS; k++)
        begin
            c = random_cmd();
            // long receiver hold-off while queries keep arriving
            if (k == 150)
                hold_req = 1'b1;
            if (k >= 150 && k < 160)
                c.op = wts_pkg::OP_QUERY;
            // sender pause until the result queue drains
            if (k == 300)
            begin
                while (pending_trends.size() != 0)
                    @(posedge clk);
            end
            send(c, 0, none);
        end
        s_tvalid <= 1'b0;

        while (pending_trends.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (errors == 0)
            $display("windowed_trend_slope verification clean");
        else
            $display("windowed_trend_slope verification failed");
        $finish;
    end

endmodule

// ===== windowed_trend_slope.f =====
+incdir+rtl
rtl/wts_pkg.sv
rtl/wts_history.sv
rtl/wts_mul.sv
rtl/wts_engine.sv
rtl/windowed_trend_slope.sv
rtl/wts_checker.sv
tb/windowed_trend_slope_test.sv
